>>> design/pmc_pkg.sv
// Shared types and constants for the PID motor controller.
`timescale 1ns / 1ps
`default_nettype none

package pmc_pkg;

    localparam int SAMPLE_WIDTH     = 16;
    localparam int GAIN_W           = 16;
    localparam int GAIN_FRAC_BITS   = 8;
    localparam int INTEG_W          = 24;
    localparam int DRIVE_W          = 8;
    localparam int DRIVE_LIMIT      = 127;
    localparam int INTEG_LIMIT_BASE = 50;
    localparam int CFG_IDX_W        = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP       = 2'd0,
        REG_KI       = 2'd1,
        REG_KD       = 2'd2,
        REG_VEL_MODE = 2'd3
    } pmc_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] target;
        logic signed [SAMPLE_WIDTH-1:0] measured;
    } pmc_sample_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      saturated;
    } pmc_result_t;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic              velocity_mode;
    } pmc_gains_t;

    typedef struct packed {
        logic signed [INTEG_W-1:0]    integral;
        logic signed [SAMPLE_WIDTH:0] last_error;
        logic signed [DRIVE_W-1:0]    held_drive;
    } pmc_state_t;

endpackage

`default_nettype wire

>>> design/pmc_limit_div.sv
// Serial restoring divider for the integral limit (base << frac) / ki.
`timescale 1ns / 1ps
`default_nettype none

module pmc_limit_div #(
    parameter int GAIN_FRAC_BITS = pmc_pkg::GAIN_FRAC_BITS,
    parameter int LIMIT_W        = $clog2((pmc_pkg::INTEG_LIMIT_BASE << GAIN_FRAC_BITS) + 1)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [pmc_pkg::GAIN_W-1:0] divisor,
    output logic                           busy,
    output logic [LIMIT_W-1:0]             limit
);
    import pmc_pkg::*;

    localparam int CNT_W = $clog2(LIMIT_W + 1);
    localparam logic [LIMIT_W-1:0] DIVIDEND = LIMIT_W'(INTEG_LIMIT_BASE << GAIN_FRAC_BITS);

    logic               busy_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [GAIN_W-1:0]  rem_reg;
    logic [GAIN_W-1:0]  dsr_reg;
    logic [LIMIT_W-1:0] quo_reg;   // dividend shifts out on top, quotient in below
    logic [GAIN_W:0]    trial;
    logic               fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[LIMIT_W-1]};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(LIMIT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= DIVIDEND;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? GAIN_W'(trial - {1'b0, dsr_reg}) : trial[GAIN_W-1:0];
            quo_reg <= {quo_reg[LIMIT_W-2:0], fits};
        end
    end

    assign busy  = busy_reg;
    assign limit = quo_reg;

endmodule

`default_nettype wire

>>> design/pmc_datapath.sv
// One control tick: error, clamped integral, derivative, gain sum, optional velocity-form add and drive saturation.
`timescale 1ns / 1ps
`default_nettype none

module pmc_datapath #(
    parameter int GAIN_FRAC_BITS = pmc_pkg::GAIN_FRAC_BITS,
    parameter int LIMIT_W        = $clog2((pmc_pkg::INTEG_LIMIT_BASE << GAIN_FRAC_BITS) + 1)
) (
    input  wire pmc_pkg::pmc_sample_t sample,
    input  wire pmc_pkg::pmc_gains_t  gains,
    input  wire pmc_pkg::pmc_state_t  state_cur,
    input  wire logic [LIMIT_W-1:0] limit,
    output pmc_pkg::pmc_state_t  state_next,
    output pmc_pkg::pmc_result_t result
);
    import pmc_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int IW    = INTEG_W;
    localparam int PP_W  = GAIN_W + 1 + SW + 1;
    localparam int PI_W  = GAIN_W + 1 + IW;
    localparam int PD_W  = GAIN_W + 1 + SW + 2;
    localparam int SUM_W = PI_W + 2;
    localparam int D_W   = SUM_W + 1;

    localparam logic signed [IW-1:0]  IMAX  = {1'b0, {(IW-1){1'b1}}};
    localparam logic signed [IW-1:0]  IMIN  = {1'b1, {(IW-1){1'b0}}};
    localparam logic signed [D_W-1:0] DLIM  = D_W'(DRIVE_LIMIT);
    localparam logic signed [D_W-1:0] DLIMN = -DLIM;

    logic signed [SW:0]      err;
    logic signed [IW:0]      isum;
    logic signed [IW-1:0]    isat;
    logic signed [IW-1:0]    iclamp;
    logic signed [IW-1:0]    lim_pos;
    logic signed [IW-1:0]    lim_neg;
    logic signed [SW+1:0]    de;
    logic signed [PP_W-1:0]  pp;
    logic signed [PI_W-1:0]  pi;
    logic signed [PD_W-1:0]  pd;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] u;
    logic signed [D_W-1:0]   d;
    logic signed [D_W-1:0]   dsat;

    always_comb
    begin
        err = {sample.target[SW-1], sample.target} - {sample.measured[SW-1], sample.measured};

        // integral: saturate to its own width, then the symmetric ki limit when ki is nonzero
        isum = {state_cur.integral[IW-1], state_cur.integral} + {{(IW-SW){err[SW]}}, err};
        if (isum[IW] != isum[IW-1])
        begin
            isat = isum[IW] ? IMIN : IMAX;
        end
        else
        begin
            isat = isum[IW-1:0];
        end

        lim_pos = {{(IW-LIMIT_W){1'b0}}, limit};
        lim_neg = -lim_pos;
        iclamp  = isat;
        if (gains.ki != '0)
        begin
            if (isat > lim_pos)
            begin
                iclamp = lim_pos;
            end
            else if (isat < lim_neg)
            begin
                iclamp = lim_neg;
            end
        end

        state_next.integral   = (err == '0) ? '0 : iclamp;
        state_next.last_error = err;

        de = {err[SW], err} - {state_cur.last_error[SW], state_cur.last_error};

        pp = $signed({1'b0, gains.kp}) * err;
        pi = $signed({1'b0, gains.ki}) * state_next.integral;
        pd = $signed({1'b0, gains.kd}) * de;

        sum = {{(SUM_W-PP_W){pp[PP_W-1]}}, pp}
            + {{(SUM_W-PI_W){pi[PI_W-1]}}, pi}
            + {{(SUM_W-PD_W){pd[PD_W-1]}}, pd};
        u = sum >>> GAIN_FRAC_BITS;   // floor

        d = {u[SUM_W-1], u};
        if (gains.velocity_mode)
        begin
            d = d + {{(D_W-DRIVE_W){state_cur.held_drive[DRIVE_W-1]}}, state_cur.held_drive};
        end

        if (d > DLIM)
        begin
            dsat = DLIM;
        end
        else if (d < DLIMN)
        begin
            dsat = DLIMN;
        end
        else
        begin
            dsat = d;
        end

        state_next.held_drive = dsat[DRIVE_W-1:0];
        result.drive          = dsat[DRIVE_W-1:0];
        result.saturated      = (dsat != d);
    end

endmodule

`default_nettype wire

>>> design/pid_motor_controller_core.sv
// Top level of the PID motor controller: handshake, config registers and state.
// An accepted word is held in the input register, then moves on to the result register.
// Throughput: one word per cycle while neither the receiver nor the limit divider stalls;
// the state loop closes within the single datapath stage. A nonzero ki write starts a
// one-bit-a-cycle divider for the integral limit; samples stall while it runs.
// Reset clears gains, mode, integral, last error, held drive and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

module pid_motor_controller_core #(
    parameter int GAIN_FRAC_BITS = pmc_pkg::GAIN_FRAC_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sample_valid,
    output logic                               sample_stall,
    input  wire pmc_pkg::pmc_sample_t          sample_word,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output pmc_pkg::pmc_result_t               result_word,
    input  wire logic                          cfg_we,
    input  wire logic [pmc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pmc_pkg::GAIN_W-1:0]    cfg_wdata
);
    import pmc_pkg::*;

    localparam int LIMIT_W = $clog2((INTEG_LIMIT_BASE << GAIN_FRAC_BITS) + 1);

    pmc_gains_t  gains_reg;
    pmc_state_t  state_reg;
    pmc_state_t  state_next;

    // input register stage
    logic        s1_valid_reg;
    pmc_sample_t s1_word_reg;

    // result register stage
    logic        res_valid_reg;
    pmc_result_t res_word_reg;
    pmc_result_t res_next;

    logic               div_start;
    logic               div_busy;
    logic [LIMIT_W-1:0] limit;
    logic               s1_adv;
    logic               accept;

    // the datapath stage moves on whenever the result register is free or draining
    assign s1_adv       = s1_valid_reg && (!res_valid_reg || !result_stall);
    assign sample_stall = div_busy || (s1_valid_reg && !s1_adv);
    assign accept       = sample_valid && !sample_stall;

    // limit recompute only matters for nonzero ki; zero ki bypasses the clamp
    assign div_start = cfg_we && (cfg_index == REG_KI) && (cfg_wdata != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KP:       gains_reg.kp            <= cfg_wdata;
                REG_KI:       gains_reg.ki            <= cfg_wdata;
                REG_KD:       gains_reg.kd            <= cfg_wdata;
                REG_VEL_MODE: gains_reg.velocity_mode <= cfg_wdata[0];
            endcase
        end
    end

    pmc_limit_div #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .LIMIT_W        (LIMIT_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (cfg_wdata),
        .busy    (div_busy),
        .limit   (limit)
    );

    pmc_datapath #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .LIMIT_W        (LIMIT_W)
    ) u_dp (
        .sample     (s1_word_reg),
        .gains      (gains_reg),
        .state_cur  (state_reg),
        .limit      (limit),
        .state_next (state_next),
        .result     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;   // state advances once per word
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_word_reg <= sample_word;
        end
        if (s1_adv)
        begin
            res_word_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result_word  = res_word_reg;

endmodule

`default_nettype wire

>>> design/pmc_checker.sv
// Port-level checks for the PID motor controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pmc_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sample_valid,
    input  wire logic                          sample_stall,
    input  wire pmc_pkg::pmc_sample_t          sample_word,
    input  wire logic                          result_valid,
    input  wire logic                          result_stall,
    input  wire pmc_pkg::pmc_result_t          result_word,
    input  wire logic                          cfg_we,
    input  wire logic [pmc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pmc_pkg::GAIN_W-1:0]    cfg_wdata
);
    import pmc_pkg::*;

    // a held result keeps its word
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_word))
        else $error("result word changed while stalled");

    // a stalled sample keeps its word
    a_sample_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_stall |=> sample_valid && $stable(sample_word))
        else $error("sample word changed while stalled");

    // a clipped drive sits exactly on the limit
    a_sat_on_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_word.saturated |->
            result_word.drive == DRIVE_W'(DRIVE_LIMIT) ||
            result_word.drive == -DRIVE_W'(DRIVE_LIMIT))
        else $error("saturated flag without limit drive");

    // an accepted word reaches the result register unless the receiver stalls it
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) ##1 !result_stall |=> result_valid)
        else $error("accepted word did not produce a result");

    // nonzero ki write holds off samples while the limit is recomputed
    a_ki_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == REG_KI && cfg_wdata != '0 |=> sample_stall)
        else $error("sample accepted during limit divide");

endmodule

bind pid_motor_controller_core pmc_checker u_pmc_checker (.*);

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the PID motor controller core.
`timescale 1ns / 1ps

module tb;
    import pmc_pkg::*;

    // Stimulus shapes for the random part.
    typedef enum int {
        RUN_NOISE,  // raw random words, every bit of both fields
        RUN_TRACK,  // measurement follows the setpoint with small error
        RUN_STEP,   // constant error held for the whole run
        RUN_HOLD    // zero error, clears the integral
    } run_kind_t;

    // One line of the directed table: a register write or a sample word.
    typedef struct packed {
        bit          is_cfg;
        pmc_reg_t    sel;
        logic [15:0] val;
        pmc_sample_t word;
        bit          fixed;   // expected result typed in below
        pmc_result_t given;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    pmc_sample_t          sample_word = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    pmc_result_t          result_word;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [GAIN_W-1:0]    cfg_wdata = '0;

    pid_motor_controller_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_word  (sample_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Predictor copy of gains and loop state.
    logic [GAIN_W-1:0] gain_kp = '0;
    logic [GAIN_W-1:0] gain_ki = '0;
    logic [GAIN_W-1:0] gain_kd = '0;
    bit                vel_form = 1'b0;
    longint            integ_cap = 0;
    longint            integ_acc = 0;
    longint            prev_err = 0;
    longint            held_drive_q = 0;

    pmc_result_t pending_drive[$];
    plan_row_t   script[$];
    bit          idle_on = 1'b0;
    int          stall_left = 0;
    int          fail_count = 0;
    int          words_sent = 0;
    int          results_seen = 0;
    int          clipped_seen = 0;

    localparam longint INTEG_MAX = (64'sd1 <<< (INTEG_W - 1)) - 1;
    localparam longint INTEG_MIN = -(64'sd1 <<< (INTEG_W - 1));

    // One control tick: integral with anti-windup, derivative, floor scaling, velocity form, saturation.
    function automatic pmc_result_t advance_pid(input pmc_sample_t w);
        longint      err;
        longint      deriv;
        longint      acc;
        longint      want;
        longint      clip;
        pmc_result_t r;
        err = longint'($signed(w.target)) - longint'($signed(w.measured));
        integ_acc = integ_acc + err;
        if (integ_acc > INTEG_MAX)
            integ_acc = INTEG_MAX;
        if (integ_acc < INTEG_MIN)
            integ_acc = INTEG_MIN;
        if (gain_ki != 0)
        begin
            if (integ_acc > integ_cap)
                integ_acc = integ_cap;
            if (integ_acc < -integ_cap)
                integ_acc = -integ_cap;
        end
        if (err == 0)
            integ_acc = 0;
        deriv = err - prev_err;
        prev_err = err;
        acc = longint'(gain_kp) * err + longint'(gain_ki) * integ_acc
            + longint'(gain_kd) * deriv;
        // arithmetic shift of a signed value rounds toward minus infinity
        want = acc >>> GAIN_FRAC_BITS;
        if (vel_form)
            want = held_drive_q + want;
        clip = want;
        if (clip > DRIVE_LIMIT)
            clip = DRIVE_LIMIT;
        if (clip < -DRIVE_LIMIT)
            clip = -DRIVE_LIMIT;
        held_drive_q = clip;
        r.drive = clip[DRIVE_W-1:0];
        r.saturated = (clip != want);
        return r;
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(1, 16'h0180));
            4: return 16'($urandom_range(0, 16'h0020));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] sat16(input int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= 40)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic add_cfg(input pmc_reg_t sel, input logic [15:0] val);
        plan_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.sel = sel;
        r.val = val;
        script.push_back(r);
    endtask

    task automatic add_word(input int t, input int m, input bit fixed,
                            input int drive, input bit sat);
        plan_row_t r;
        r = '0;
        r.word.target = 16'(t);
        r.word.measured = 16'(m);
        r.fixed = fixed;
        r.given.drive = 8'(drive);
        r.given.saturated = sat;
        script.push_back(r);
    endtask

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input pmc_sample_t w, input bit fixed, input pmc_result_t given);
        pmc_result_t due;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            sample_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        sample_valid = 1'b1;
        sample_word = w;
        due = advance_pid(w);
        do
            @(posedge clk);
        while (sample_stall);
        pending_drive.push_back(fixed ? given : due);
        words_sent++;
        @(negedge clk);
    endtask

    // Stop sending and wait until the pipe has emptied.
    task automatic settle_idle();
        sample_valid = 1'b0;
        while (pending_drive.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_gain(input pmc_reg_t sel, input logic [15:0] val);
        cfg_we = 1'b1;
        cfg_index = sel;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (sel)
            REG_KP: gain_kp = val;
            REG_KI:
            begin
                gain_ki = val;
                integ_cap = (val != 0) ? (longint'(INTEG_LIMIT_BASE) << GAIN_FRAC_BITS) / val : 0;
            end
            REG_KD: gain_kd = val;
            REG_VEL_MODE: vel_form = val[0];
            default: ;
        endcase
    endtask

    // Receiver backpressure in short random bursts.
    always @(negedge clk)
    begin
        if (idle_on && stall_left == 0 && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 4);
        if (stall_left > 0)
        begin
            result_stall = 1'b1;
            stall_left = stall_left - 1;
        end
        else
            result_stall = 1'b0;
    end

    always @(posedge clk)
    begin : result_check
        pmc_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (result_word.saturated)
                clipped_seen++;
            if (pending_drive.size() == 0)
                report_mismatch("result word with nothing pending");
            else
            begin
                want = pending_drive.pop_front();
                if (result_word.drive !== want.drive)
                    report_mismatch($sformatf("drive %0d, expected %0d",
                        result_word.drive, want.drive));
                if (result_word.saturated !== want.saturated)
                    report_mismatch($sformatf("saturated %0b, expected %0b",
                        result_word.saturated, want.saturated));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAIL pid_motor_controller_core");
        $finish;
    end

    initial
    begin : stimulus
        pmc_sample_t w;
        run_kind_t   kind;
        int          phase;
        int          budget;
        int          sent;
        int          run_len;
        int          k;
        int          base;
        int          err;
        int          lvl;
        int          guard;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed table. Gains are zero out of reset, so drive stays zero.
        add_word(32767, -32768, 1, 0, 0);
        add_word(-32768, 32767, 1, 0, 0);
        // Unity proportional gain: drive equals the error up to the clip.
        add_cfg(REG_KP, 16'h0100);
        add_word(100, 0, 1, 100, 0);
        add_word(127, 0, 1, 127, 0);
        add_word(128, 0, 1, 127, 1);
        add_word(0, 127, 1, -127, 0);
        add_word(0, 128, 1, -127, 1);
        add_word(32767, -32768, 1, 127, 1);
        add_word(-32768, 32767, 1, -127, 1);
        // Half gain: negative fractions round down.
        add_cfg(REG_KP, 16'h0080);
        add_word(0, 1, 1, -1, 0);
        add_word(1, 0, 1, 0, 0);
        add_word(0, 3, 1, -2, 0);
        add_cfg(REG_KP, 16'hFFFF);
        add_word(1, 0, 1, 127, 1);
        // Integral only, limit 50; zero error clears it.
        add_cfg(REG_KP, 16'h0000);
        add_cfg(REG_KI, 16'h0100);
        add_word(1000, 0, 0, 0, 0);
        add_word(1000, 0, 0, 0, 0);
        add_word(-5, -5, 1, 0, 0);
        add_word(-1000, 0, 0, 0, 0);
        // Largest ki leaves a zero limit, so the integral term vanishes.
        add_cfg(REG_KI, 16'hFFFF);
        add_word(2000, 0, 1, 0, 0);
        add_cfg(REG_KI, 16'h0000);
        add_cfg(REG_KD, 16'hFFFF);
        add_word(0, 0, 0, 0, 0);
        add_word(1, 0, 0, 0, 0);
        // Velocity form accumulates on the held drive.
        add_cfg(REG_KD, 16'h0000);
        add_cfg(REG_KP, 16'h0100);
        add_cfg(REG_VEL_MODE, 16'h0001);
        add_word(10, 0, 0, 0, 0);
        add_word(10, 0, 0, 0, 0);
        add_word(-300, 0, 0, 0, 0);
        // Position form still records the drive for a later switch.
        add_cfg(REG_VEL_MODE, 16'h0000);
        add_word(5, 0, 1, 5, 0);
        add_cfg(REG_VEL_MODE, 16'h0001);
        add_word(0, 0, 1, 5, 0);

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                settle_idle();
                write_gain(script[i].sel, script[i].val);
            end
            else
                send_word(script[i].word, script[i].fixed, script[i].given);
        end

        // Random phases. Phase 0 winds the integral to both rails with ki at zero,
        // phase 1 then makes the saturated integral visible through a small limit,
        // phase 2 runs every gain at its maximum, the last phase has no idling.
        for (phase = 0; phase < 10; phase++)
        begin
            // any leftover stall burst runs out while the pipe drains
            if (phase == 9)
                idle_on = 1'b0;
            settle_idle();
            write_gain(REG_KP, (phase == 2) ? 16'hFFFF : pick_gain());
            write_gain(REG_KI, (phase == 0) ? 16'h0000 :
                               (phase == 1) ? 16'h0100 :
                               (phase == 2) ? 16'hFFFF : pick_gain());
            write_gain(REG_KD, (phase == 2) ? 16'hFFFF : pick_gain());
            write_gain(REG_VEL_MODE, {15'b0, phase[0]});
            budget = (phase == 0) ? 420 : 140;
            sent = 0;
            while (sent < budget)
            begin
                idle_on = (phase != 9) && ($urandom_range(0, 3) != 0);
                run_len = $urandom_range(5, 40);
                case ($urandom_range(0, 9))
                    0, 1: kind = RUN_NOISE;
                    7, 8: kind = RUN_STEP;
                    9: kind = RUN_HOLD;
                    default: kind = RUN_TRACK;
                endcase
                base = $urandom_range(0, 65535) - 32768;
                lvl = $urandom_range(1, 300);
                err = $urandom_range(0, 2 * lvl) - lvl;
                if (phase == 0)
                begin
                    // full negative swing first, then full positive for twice as long
                    kind = RUN_STEP;
                    run_len = (sent == 0) ? 140 : 280;
                end
                if (kind == RUN_STEP && ($urandom_range(0, 2) == 0 || phase == 0))
                    err = (phase == 0 && sent == 0) ? -65535 :
                          (phase == 0) ? 65535 : ($urandom_range(0, 1) ? 65535 : -65535);
                for (k = 0; k < run_len && sent < budget; k++)
                begin
                    case (kind)
                        RUN_NOISE: w = $urandom;
                        RUN_TRACK:
                        begin
                            base = base + $urandom_range(0, 40) - 20;
                            err = ($urandom_range(0, 7) == 0) ? 0 :
                                  $urandom_range(0, 2 * lvl) - lvl;
                            w.measured = sat16(base);
                            w.target = sat16(base + err);
                        end
                        RUN_STEP:
                        begin
                            if (err == 65535 || err == -65535)
                            begin
                                w.target = (err > 0) ? 16'sh7FFF : 16'sh8000;
                                w.measured = (err > 0) ? 16'sh8000 : 16'sh7FFF;
                            end
                            else
                            begin
                                w.measured = sat16(base);
                                w.target = sat16(base + err);
                            end
                        end
                        default:
                        begin
                            w.measured = 16'($urandom);
                            w.target = w.measured;
                        end
                    endcase
                    send_word(w, 1'b0, '0);
                    sent++;
                end
            end
        end

        sample_valid = 1'b0;
        idle_on = 1'b0;
        guard = 0;
        while (pending_drive.size() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (10) @(negedge clk);
        if (pending_drive.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_drive.size()));

        $display("Covered %0d sample words over 10 gain settings in both forms,", words_sent);
        $display("%0d results checked, %0d of them clipped, %0d mismatches.",
            results_seen, clipped_seen, fail_count);
        if (fail_count == 0)
            $display("PASS pid_motor_controller_core");
        else
            $display("FAIL pid_motor_controller_core");
        $finish;
    end

endmodule

>>> filelist.f
design/pmc_pkg.sv
design/pmc_limit_div.sv
design/pmc_datapath.sv
design/pid_motor_controller_core.sv
design/pmc_checker.sv
test/tb.sv
